FILE: src/b52c_pkg.sv
// ----------------------------------------------------------------------------
// Base-52 pair codec package
// Shared types, status codes, arithmetic constants and alphabet mapping
// functions of the base-52 pair text codec.
// ----------------------------------------------------------------------------
package b52c_pkg;

   localparam int unsigned RADIX    = 52;
   localparam int unsigned RADIX_SQ = RADIX * RADIX;

   // Exact reciprocal for a 16-bit value divided by RADIX_SQ.
   localparam int unsigned HI_RECIP = 99274;
   localparam int unsigned HI_SHIFT = 28;
   // Exact reciprocal for a 12-bit value divided by RADIX.
   localparam int unsigned LO_RECIP = 5042;
   localparam int unsigned LO_SHIFT = 18;

   localparam int unsigned NUM_RANGES = 9;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_BAD_CHAR = 2'd1,
      STATUS_BAD_LEN  = 2'd2,
      STATUS_OVERFLOW = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      JOB_ENC = 2'd0,
      JOB_DEC = 2'd1,
      JOB_ERR = 2'd2
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      logic [15:0]  value;
      status_type   status;
      logic         last;
   } job_type;

   typedef struct packed {
      logic       valid;
      logic [5:0] digit;
   } digit_type;

   // Character ranges of the alphabet, in digit order.
   localparam logic [7:0] CHAR_LO [NUM_RANGES] = '{
      8'h33, 8'h36, 8'h61, 8'h6D, 8'h41, 8'h45, 8'h4A, 8'h50, 8'h54};
   localparam logic [7:0] CHAR_HI [NUM_RANGES] = '{
      8'h34, 8'h39, 8'h6B, 8'h7A, 8'h43, 8'h48, 8'h4E, 8'h52, 8'h59};
   // First and last digit of each range.
   localparam logic [5:0] DIG_LO [NUM_RANGES] = '{
      6'd0, 6'd2, 6'd6, 6'd17, 6'd31, 6'd34, 6'd38, 6'd43, 6'd46};
   localparam logic [5:0] DIG_HI [NUM_RANGES] = '{
      6'd1, 6'd5, 6'd16, 6'd30, 6'd33, 6'd37, 6'd42, 6'd45, 6'd51};
   // Character code minus digit, constant within a range.
   localparam logic [7:0] CHAR_BASE [NUM_RANGES] = '{
      8'h33, 8'h34, 8'h5B, 8'h5C, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26};

   function automatic digit_type char_to_digit(input logic [7:0] ch);
      digit_type res;
      logic [7:0] diff;
      res = '0;
      for (int r = 0; r < NUM_RANGES; r++) begin
         diff = ch - CHAR_BASE[r];
         if (ch >= CHAR_LO[r] && ch <= CHAR_HI[r]) begin
            res.valid = 1'b1;
            res.digit = diff[5:0];
         end
      end
      return res;
   endfunction

   function automatic logic [7:0] digit_to_char(input logic [5:0] d);
      logic [7:0] res;
      res = '0;
      for (int r = 0; r < NUM_RANGES; r++) begin
         if (d >= DIG_LO[r] && d <= DIG_HI[r]) begin
            res = {2'b00, d} + CHAR_BASE[r];
         end
      end
      return res;
   endfunction

endpackage

FILE: src/base52_pair_text_codec.sv
// ----------------------------------------------------------------------------
// Base-52 pair text codec
// Streaming encoder and decoder between byte pairs and three-character
// base-52 groups, with a direction register and per-word status.
// ----------------------------------------------------------------------------
// The front end takes one input word per cycle while the job queue has room
// and no direction write is pending, and emits nothing for words that only
// extend a group. The back end sends one result word per cycle when the
// output is free, after loading each job while idle: three characters for
// an encoded byte pair, two bytes for a decoded character triple and one
// word for an error. That back-end sequencer sets the sustained rate; the
// queue of QUEUE_DEPTH jobs (2 or more) lets input bursts run ahead of it.
// Write the direction register only while no message is in flight; a write
// also discards any partial group.
module base52_pair_text_codec #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,    // [7:0] in_symbol
   input  logic       req_tlast,    // in_last
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,    // [7:0] out_symbol
   output logic [2:0] rsp_tuser,    // [1:0] status, [2] run_last
   output logic       rsp_tlast,    // message_end
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_wdata     // direction
);

   logic              queue_full;
   logic              push_valid;
   b52c_pkg::job_type push_job;
   logic              job_avail;
   logic              job_pop;
   b52c_pkg::job_type head_job;

   b52c_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_job   (push_job)
   );

   b52c_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .full       (queue_full),
      .pop_avail  (job_avail),
      .pop        (job_pop),
      .pop_job    (head_job)
   );

   b52c_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_avail  (job_avail),
      .job_pop    (job_pop),
      .job        (head_job),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: src/b52c_front.sv
// ----------------------------------------------------------------------------
// Base-52 pair codec front end
// Accepts input words, keeps the partial group and the direction register,
// and turns each completed group or error into a job for the back end.
// ----------------------------------------------------------------------------
module b52c_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,   // [7:0] in_symbol
   input  logic              req_tlast,   // in_last
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_wdata,   // direction
   input  logic              queue_full,
   output logic              push_valid,
   output b52c_pkg::job_type push_job
);

   logic        direction_ff, direction_in;
   logic [17:0] group_value_ff, group_value_in;
   logic [1:0]  group_count_ff, group_count_in;

   logic                 accept;
   b52c_pkg::digit_type  in_digit;
   logic [17:0]          acc_base;
   logic [23:0]          acc_wide;
   logic [17:0]          acc_value;

   // A direction write takes the cycle, so no input word is taken with it.
   assign req_tready = !queue_full && !csr_valid;
   assign csr_ready  = 1'b1;
   assign accept     = req_tvalid && req_tready;

   assign in_digit  = b52c_pkg::char_to_digit(req_tdata);
   assign acc_base  = (group_count_ff == 2'd0) ? 18'd0 : group_value_ff;
   assign acc_wide  = {6'd0, acc_base} * 24'(b52c_pkg::RADIX) + {18'd0, in_digit.digit};
   assign acc_value = acc_wide[17:0];

   always_comb begin
      direction_in   = direction_ff;
      group_value_in = group_value_ff;
      group_count_in = group_count_ff;
      push_valid     = 1'b0;
      push_job.kind   = b52c_pkg::JOB_ERR;
      push_job.value  = 16'd0;
      push_job.status = b52c_pkg::STATUS_OK;
      push_job.last   = req_tlast;

      if (csr_valid) begin
         direction_in   = csr_wdata;
         group_value_in = 18'd0;
         group_count_in = 2'd0;
      end else if (accept) begin
         if (!direction_ff) begin
            if (group_count_ff == 2'd0) begin
               if (req_tlast) begin
                  push_valid      = 1'b1;
                  push_job.status = b52c_pkg::STATUS_BAD_LEN;
               end else begin
                  group_value_in = {10'd0, req_tdata};
                  group_count_in = 2'd1;
               end
            end else begin
               push_valid     = 1'b1;
               push_job.kind  = b52c_pkg::JOB_ENC;
               push_job.value = {group_value_ff[7:0], req_tdata};
               group_value_in = 18'd0;
               group_count_in = 2'd0;
            end
         end else begin
            if (!in_digit.valid) begin
               push_valid      = 1'b1;
               push_job.status = b52c_pkg::STATUS_BAD_CHAR;
               group_value_in  = 18'd0;
               group_count_in  = 2'd0;
            end else if (group_count_ff < 2'd2) begin
               if (req_tlast) begin
                  push_valid      = 1'b1;
                  push_job.status = b52c_pkg::STATUS_BAD_LEN;
                  group_value_in  = 18'd0;
                  group_count_in  = 2'd0;
               end else begin
                  group_value_in = acc_value;
                  group_count_in = group_count_ff + 2'd1;
               end
            end else begin
               push_valid      = 1'b1;
               push_job.kind   = b52c_pkg::JOB_DEC;
               push_job.value  = acc_value[15:0];
               push_job.status = (acc_value[17:16] != 2'd0) ? b52c_pkg::STATUS_OVERFLOW
                                                             : b52c_pkg::STATUS_OK;
               group_value_in  = 18'd0;
               group_count_in  = 2'd0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff   <= 1'b0;
         group_value_ff <= 18'd0;
         group_count_ff <= 2'd0;
      end else begin
         direction_ff   <= direction_in;
         group_value_ff <= group_value_in;
         group_count_ff <= group_count_in;
      end
   end

endmodule

FILE: src/b52c_queue.sv
// ----------------------------------------------------------------------------
// Base-52 pair codec job queue
// Small first-in first-out buffer of jobs between the front and back ends.
// ----------------------------------------------------------------------------
module b52c_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  b52c_pkg::job_type push_job,
   output logic              full,
   output logic              pop_avail,
   input  logic              pop,
   output b52c_pkg::job_type pop_job
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   b52c_pkg::job_type entry_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign full      = (count_ff == CW'(DEPTH));
   assign pop_avail = (count_ff != '0);
   assign pop_job   = entry_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && pop_avail;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

FILE: src/b52c_back.sv
// ----------------------------------------------------------------------------
// Base-52 pair codec back end
// Takes jobs from the queue and sends their result words one at a time,
// splitting byte pairs into three base-52 characters, one state per character.
// ----------------------------------------------------------------------------
module b52c_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_avail,
   output logic              job_pop,
   input  b52c_pkg::job_type job,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,   // [7:0] out_symbol
   output logic [2:0]        rsp_tuser,   // [1:0] status, [2] run_last
   output logic              rsp_tlast    // message_end
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ENC0,
      ST_ENC1,
      ST_ENC2,
      ST_DEC0,
      ST_DEC1,
      ST_ERR
   } state_type;

   state_type             state_ff, state_in;
   b52c_pkg::job_type     job_ff, job_in;
   logic [4:0]            d0_ff, d0_in;
   logic [11:0]           rem_ff, rem_in;
   logic [5:0]            d1_ff, d1_in;
   logic                  valid_ff, valid_in;
   logic [7:0]            symbol_ff, symbol_in;
   b52c_pkg::status_type  status_ff, status_in;
   logic                  run_last_ff, run_last_in;
   logic                  msg_end_ff, msg_end_in;

   logic        out_free;
   logic [32:0] hi_prod;
   logic [15:0] hi_part;
   logic [15:0] rem_full;
   logic [24:0] lo_prod;
   logic [5:0]  d1_now;
   logic [11:0] d2_full;

   assign out_free = !valid_ff || rsp_tready;

   // Most significant digit of the pair, straight from the queue head.
   assign hi_prod  = {17'd0, job.value} * 33'(b52c_pkg::HI_RECIP);
   assign hi_part  = {11'd0, d0_ff} * 16'(b52c_pkg::RADIX_SQ);
   assign rem_full = job_ff.value - hi_part;
   assign lo_prod  = {13'd0, rem_ff} * 25'(b52c_pkg::LO_RECIP);
   assign d1_now   = lo_prod[b52c_pkg::LO_SHIFT +: 6];
   assign d2_full  = rem_ff - {6'd0, d1_ff} * 12'(b52c_pkg::RADIX);

   always_comb begin
      state_in    = state_ff;
      job_in      = job_ff;
      d0_in       = d0_ff;
      rem_in      = rem_ff;
      d1_in       = d1_ff;
      valid_in    = valid_ff && !rsp_tready;
      symbol_in   = symbol_ff;
      status_in   = status_ff;
      run_last_in = run_last_ff;
      msg_end_in  = msg_end_ff;
      job_pop     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (job_avail) begin
               job_pop = 1'b1;
               job_in  = job;
               d0_in   = hi_prod[b52c_pkg::HI_SHIFT +: 5];
               unique case (job.kind)
                  b52c_pkg::JOB_ENC: state_in = ST_ENC0;
                  b52c_pkg::JOB_DEC: state_in = ST_DEC0;
                  b52c_pkg::JOB_ERR: state_in = ST_ERR;
                  default:           state_in = ST_IDLE;
               endcase
            end
         end
         ST_ENC0: begin
            if (out_free) begin
               valid_in    = 1'b1;
               symbol_in   = b52c_pkg::digit_to_char({1'b0, d0_ff});
               status_in   = b52c_pkg::STATUS_OK;
               run_last_in = 1'b0;
               msg_end_in  = 1'b0;
               rem_in      = rem_full[11:0];
               state_in    = ST_ENC1;
            end
         end
         ST_ENC1: begin
            if (out_free) begin
               valid_in    = 1'b1;
               symbol_in   = b52c_pkg::digit_to_char(d1_now);
               status_in   = b52c_pkg::STATUS_OK;
               run_last_in = 1'b0;
               msg_end_in  = 1'b0;
               d1_in       = d1_now;
               state_in    = ST_ENC2;
            end
         end
         ST_ENC2: begin
            if (out_free) begin
               valid_in    = 1'b1;
               symbol_in   = b52c_pkg::digit_to_char(d2_full[5:0]);
               status_in   = b52c_pkg::STATUS_OK;
               run_last_in = 1'b1;
               msg_end_in  = job_ff.last;
               state_in    = ST_IDLE;
            end
         end
         ST_DEC0: begin
            if (out_free) begin
               valid_in    = 1'b1;
               symbol_in   = job_ff.value[15:8];
               status_in   = job_ff.status;
               run_last_in = 1'b0;
               msg_end_in  = 1'b0;
               state_in    = ST_DEC1;
            end
         end
         ST_DEC1: begin
            if (out_free) begin
               valid_in    = 1'b1;
               symbol_in   = job_ff.value[7:0];
               status_in   = job_ff.status;
               run_last_in = 1'b1;
               msg_end_in  = job_ff.last;
               state_in    = ST_IDLE;
            end
         end
         ST_ERR: begin
            if (out_free) begin
               valid_in    = 1'b1;
               symbol_in   = 8'd0;
               status_in   = job_ff.status;
               run_last_in = 1'b1;
               msg_end_in  = job_ff.last;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      job_ff      <= job_in;
      d0_ff       <= d0_in;
      rem_ff      <= rem_in;
      d1_ff       <= d1_in;
      symbol_ff   <= symbol_in;
      status_ff   <= status_in;
      run_last_ff <= run_last_in;
      msg_end_ff  <= msg_end_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = symbol_ff;
   assign rsp_tuser  = {run_last_ff, status_ff};
   assign rsp_tlast  = msg_end_ff;

endmodule

FILE: tb/tb_base52_pair_text_codec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base-52 pair text codec testbench
// Drives byte pairs and character triples through the codec in both
// directions and checks every result word against a cycle-free predictor,
// with random gaps on the input, random output stalls and one long hold-off.
// ----------------------------------------------------------------------------
module tb_base52_pair_text_codec;

   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned DRAIN_CYCLES = 24;
   localparam int unsigned GROUP_RANGE  = 52 * 52 * 52;
   // Digit d is the character at position d, counting from the left.
   localparam logic [8*52-1:0] ALPHABET =
      "346789abcdefghijkmnopqrstuvwxyzABCEFGHJKLMNPQRTUVWXY";

   typedef struct packed {
      logic [7:0]           symbol;
      b52c_pkg::status_type status;
      logic                 run_last;
      logic                 msg_end;
   } result_word_type;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;
   logic       req_tlast  = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic [2:0] rsp_tuser;
   logic       rsp_tlast;
   logic       csr_valid  = 1'b0;
   logic       csr_ready;
   logic       csr_wdata  = 1'b0;

   // Predictor state.
   logic        dir_decode;
   logic [17:0] grp_value;
   logic [1:0]  grp_count;

   result_word_type pending_words[$];
   result_word_type want;

   int unsigned sender_idle_pct    = 0;
   int unsigned receiver_stall_pct = 0;
   int unsigned hold_left          = 0;
   int unsigned cycle_count        = 0;
   int unsigned error_count        = 0;
   int unsigned words_sent         = 0;
   int unsigned words_checked      = 0;
   int unsigned status_seen[4]     = '{0, 0, 0, 0};

   base52_pair_text_codec dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Output side: a long hold-off takes priority over the random stalls.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_words.size() == 0) begin
            $error("unexpected result word: symbol %h status %0d", rsp_tdata,
                   rsp_tuser[1:0]);
            error_count++;
         end else begin
            want = pending_words.pop_front();
            words_checked++;
            if (rsp_tdata !== want.symbol) begin
               $error("out_symbol: expected %h, got %h", want.symbol, rsp_tdata);
               error_count++;
            end
            if (rsp_tuser[1:0] !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_tuser[1:0]);
               error_count++;
            end
            if (rsp_tuser[2] !== want.run_last) begin
               $error("run_last: expected %b, got %b", want.run_last, rsp_tuser[2]);
               error_count++;
            end
            if (rsp_tlast !== want.msg_end) begin
               $error("message_end: expected %b, got %b", want.msg_end, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   function automatic logic [7:0] char_of(input int unsigned digit);
      return ALPHABET[8*(51-digit) +: 8];
   endfunction

   function automatic int digit_of(input logic [7:0] ch);
      for (int d = 0; d < 52; d++) begin
         if (char_of(d) == ch) begin
            return d;
         end
      end
      return -1;
   endfunction

   task automatic push_word(input logic [7:0] symbol, input b52c_pkg::status_type status,
                            input logic run_last, input logic msg_end);
      result_word_type word;
      word.symbol   = symbol;
      word.status   = status;
      word.run_last = run_last;
      word.msg_end  = msg_end;
      pending_words.insert(pending_words.size(), word);
      status_seen[status]++;
   endtask

   task automatic clear_group();
      grp_value = '0;
      grp_count = '0;
   endtask

   // Works out the result words caused by one accepted input word.
   task automatic predict_codec_words(input logic [7:0] symbol, input logic last);
      logic [15:0]          pair;
      int                   digit;
      int unsigned          gathered;
      b52c_pkg::status_type st;
      if (!dir_decode) begin
         if (grp_count == 0) begin
            if (last) begin
               push_word(8'h00, b52c_pkg::STATUS_BAD_LEN, 1'b1, 1'b1);
               clear_group();
            end else begin
               grp_value = {10'd0, symbol};
               grp_count = 2'd1;
            end
         end else begin
            pair = {grp_value[7:0], symbol};
            push_word(char_of(pair / (52 * 52)), b52c_pkg::STATUS_OK, 1'b0, 1'b0);
            push_word(char_of((pair / 52) % 52), b52c_pkg::STATUS_OK, 1'b0, 1'b0);
            push_word(char_of(pair % 52), b52c_pkg::STATUS_OK, 1'b1, last);
            clear_group();
         end
      end else begin
         digit = digit_of(symbol);
         if (digit < 0) begin
            push_word(8'h00, b52c_pkg::STATUS_BAD_CHAR, 1'b1, last);
            clear_group();
         end else begin
            gathered = ((grp_count == 0 ? 0 : grp_value) * 52 + digit) & 18'h3FFFF;
            if (grp_count < 2) begin
               if (last) begin
                  push_word(8'h00, b52c_pkg::STATUS_BAD_LEN, 1'b1, 1'b1);
                  clear_group();
               end else begin
                  grp_value = gathered[17:0];
                  grp_count = grp_count + 2'd1;
               end
            end else begin
               st = (gathered > 16'hFFFF) ? b52c_pkg::STATUS_OVERFLOW
                                          : b52c_pkg::STATUS_OK;
               push_word(gathered[15:8], st, 1'b0, 1'b0);
               push_word(gathered[7:0], st, 1'b1, last);
               clear_group();
            end
         end
      end
   endtask

   // Called at the step where the previous word was taken, so a gap lowers
   // tvalid in that same step and a back-to-back word keeps it high.
   task automatic send_word(input logic [7:0] symbol, input logic last);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= symbol;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      predict_codec_words(symbol, last);
      words_sent++;
   endtask

   task automatic send_group(input int unsigned value, input logic last);
      send_word(char_of(value / (52 * 52)), 1'b0);
      send_word(char_of((value / 52) % 52), 1'b0);
      send_word(char_of(value % 52), last);
   endtask

   // Must follow the last send_word directly, before any clock edge.
   task automatic finish_stream();
      req_tvalid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_direction(input logic value);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid  <= 1'b0;
      dir_decode = value;
      clear_group();
   endtask

   task automatic test_encode_edges();
      write_direction(1'b0);
      send_word(8'h00, 1'b0);
      send_word(8'h00, 1'b0);
      send_word(8'hFF, 1'b0);
      send_word(8'hFF, 1'b1);
      // Odd message length: the third byte is left alone at the end.
      send_word(8'h12, 1'b0);
      send_word(8'h34, 1'b0);
      send_word(8'h56, 1'b1);
      finish_stream();
   endtask

   task automatic test_dir_write_clears_group();
      send_word(8'hAB, 1'b0);
      finish_stream();
      write_direction(1'b0);
      // With the pending byte dropped, a lone last byte is a length error.
      send_word(8'h00, 1'b1);
      finish_stream();
   endtask

   task automatic test_decode_edges();
      write_direction(1'b1);
      send_group(0, 1'b0);
      send_group(16'hFFFF, 1'b0);
      send_group(32'h10000, 1'b1);
      send_group(GROUP_RANGE - 1, 1'b1);
      send_word(char_of(0), 1'b0);
      send_word("Z", 1'b0);
      send_word(8'hFF, 1'b1);
      send_word(char_of(1), 1'b0);
      send_word(char_of(51), 1'b1);
      finish_stream();
   endtask

   task automatic test_random_encode(input int unsigned count);
      int unsigned sent;
      int unsigned len;
      sent = 0;
      while (sent < count) begin
         len = $urandom_range(1, 4) * 2;
         if ($urandom_range(9) < 2) begin
            len = len - 1;
         end
         for (int i = 0; i < len; i++) begin
            send_word(8'($urandom_range(0, 255)), i == len - 1);
         end
         sent += len;
      end
      finish_stream();
   endtask

   task automatic test_random_decode(input int unsigned count);
      int unsigned sent;
      int unsigned len;
      int unsigned pick;
      logic [7:0]  ch;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(99);
         if (pick < 75) begin
            len = $urandom_range(1, 3);
            for (int g = 0; g < len; g++) begin
               send_group($urandom_range(0, GROUP_RANGE - 1), g == len - 1);
            end
            sent += 3 * len;
         end else if (pick < 90) begin
            // Short message of one to five characters, with stray codes mixed in.
            len = $urandom_range(1, 5);
            for (int i = 0; i < len; i++) begin
               ch = ($urandom_range(3) == 0) ? 8'($urandom_range(0, 255))
                                              : char_of($urandom_range(0, 51));
               send_word(ch, i == len - 1);
            end
            sent += len;
         end else begin
            send_word(8'($urandom_range(0, 255)), 1'($urandom_range(1)));
            sent++;
         end
      end
      finish_stream();
   endtask

   // The output holds off long enough for the job queue to fill and stall
   // the input while byte pairs keep arriving back to back.
   task automatic test_output_backpressure();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      write_direction(1'b0);
      hold_left = 300;
      for (int i = 0; i < 36; i++) begin
         send_word(8'($urandom_range(0, 255)), i == 35);
      end
      finish_stream();
   endtask

   initial begin
      dir_decode = 1'b0;
      clear_group();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_encode_edges();
      test_dir_write_clears_group();
      test_decode_edges();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 61; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 61; end
            default: begin sender_idle_pct = 10; receiver_stall_pct = 10; end
         endcase
         write_direction(1'b0);
         test_random_encode(45);
         write_direction(1'b1);
         test_random_decode(50);
      end

      test_output_backpressure();

      $display("Sent %0d input words and checked %0d result words in both directions,",
               words_sent, words_checked);
      $display("with %0d ok, %0d bad char, %0d bad length and %0d overflow results.",
               status_seen[b52c_pkg::STATUS_OK], status_seen[b52c_pkg::STATUS_BAD_CHAR],
               status_seen[b52c_pkg::STATUS_BAD_LEN],
               status_seen[b52c_pkg::STATUS_OVERFLOW]);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
